[sv/sphere_ray_and_point_query_assert.svh]
// Assertion macros shared by the sphere query checker.
// Needs nothing else; included by the checker file.
`ifndef SPHERE_RAY_AND_POINT_QUERY_ASSERT_SVH
`define SPHERE_RAY_AND_POINT_QUERY_ASSERT_SVH
// same-cycle implication
`define SPRQ_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sphere query check failed");
// next-cycle implication
`define SPRQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sphere query check failed");
`endif

[sv/sprq_pkg.sv]
// Shared widths, register indexes and result type of the sphere query unit.
// No dependencies.
package sprq_pkg;

   localparam int PT_W    = 32;   // coordinates, test value
   localparam int DIR_W   = 18;   // direction components
   localparam int RAD_W   = 31;   // radius
   localparam int DIFF_W  = 33;   // center minus point
   localparam int PROD_W  = 51;   // direction times difference
   localparam int A1_W    = 52;   // dot product, signed
   localparam int AM_W    = 51;   // dot product magnitude when positive
   localparam int ALO_W   = 26;   // low split of magnitude
   localparam int AHI_W   = 25;   // high split of magnitude
   localparam int SQ_W    = 66;   // squares and squared distance
   localparam int R2_W    = 62;   // radius squared
   localparam int A1SQ_W  = 102;  // dot product squared
   localparam int ROOTB_W = 33;   // root of squared distance
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              ray_hit;
      logic [30:0]       hit_distance;
      logic              point_inside;
      logic signed [31:0] surface_distance;
      logic              within_test;
   } rsp_type;

endpackage

[sv/sphere_ray_and_point_query.sv]
// Sphere query unit: takes one point/ray item per cycle while the skid slot is empty
// and returns, per item, a ray hit flag with entry distance, a strictly-inside flag,
// the saturated signed surface distance and a threshold flag. Throughput is one
// transfer per cycle while nothing waits in the skid register. The pipe holds 6
// arithmetic stages, 33 root cells for the center distance, DW/2 root cells for the
// ray discriminant (DW = max(102, 66 + 2*FRAC_BITS), so 51 at FRAC_BITS = 16) and
// one output register. The two square-root chains, one cell per root bit, make up
// most of that depth. The whole pipe advances together and stops only when a result waits in the skid register.
// Depends on sprq_pkg and sprq_isqrt_cell.
module sphere_ray_and_point_query #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sprq_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sprq_pkg::CSR_DAT_W-1:0]        csr_wdata,
   // query input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [31:0]                    req_point_x,
   input  logic signed [31:0]                    req_point_y,
   input  logic signed [31:0]                    req_point_z,
   input  logic signed [17:0]                    req_dir_x,
   input  logic signed [17:0]                    req_dir_y,
   input  logic signed [17:0]                    req_dir_z,
   input  logic signed [31:0]                    req_test_value,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_ray_hit,
   output logic [30:0]                           rsp_hit_distance,
   output logic                                  rsp_point_inside,
   output logic signed [31:0]                    rsp_surface_distance,
   output logic                                  rsp_within_test
);
   // discriminant width and root lengths
   localparam int A0_W = sprq_pkg::SQ_W + 2 * FRAC_BITS;
   localparam int DW   = (A0_W > sprq_pkg::A1SQ_W) ? A0_W : sprq_pkg::A1SQ_W;
   localparam int QA   = DW / 2;
   localparam int QB   = sprq_pkg::SQ_W / 2;
   localparam int NF   = 6;
   localparam int NC   = QB + QA;

   typedef struct packed {
      logic [DW-1:0]               disc;
      logic                        ok;
      logic [sprq_pkg::AM_W-1:0]   am;
      logic [sprq_pkg::RAD_W-1:0]  r;
      logic                        lt;
      logic                        wt;
   } sideb_type;

   typedef struct packed {
      logic [sprq_pkg::ROOTB_W-1:0] rootb;
      logic                         ok;
      logic [sprq_pkg::AM_W-1:0]    am;
      logic [sprq_pkg::RAD_W-1:0]   r;
      logic                         lt;
      logic                         wt;
   } sidea_type;

   // ---------------- configuration registers ----------------
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0]        rad_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         cz_ff  <= '0;
         rad_ff <= '0;
      end else if (csr_valid) begin
         unique case (sprq_pkg::csr_index_type'(csr_index))
            sprq_pkg::CSR_CENTER_X: cx_ff  <= csr_wdata;
            sprq_pkg::CSR_CENTER_Y: cy_ff  <= csr_wdata;
            sprq_pkg::CSR_CENTER_Z: cz_ff  <= csr_wdata;
            sprq_pkg::CSR_RADIUS:   rad_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // Pipe moves while the skid slot is empty.
   logic           en;
   logic           skid_v_ff;
   logic [NF-1:0]  fv_ff;
   logic [NC-1:0]  cv_ff;

   assign en        = !skid_v_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
         cv_ff <= '0;
      end else if (en) begin
         fv_ff <= {fv_ff[NF-2:0], req_valid};
         cv_ff <= {cv_ff[NC-2:0], fv_ff[NF-1]};
      end
   end

   // ---------------- S1: differences ----------------
   logic signed [sprq_pkg::DIFF_W-1:0] dx_ff, dy_ff, dz_ff, tr_ff;
   logic signed [17:0]                 ux_ff, uy_ff, uz_ff;
   logic [30:0]                        r1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= {cx_ff[31], cx_ff} - {req_point_x[31], req_point_x};
         dy_ff <= {cy_ff[31], cy_ff} - {req_point_y[31], req_point_y};
         dz_ff <= {cz_ff[31], cz_ff} - {req_point_z[31], req_point_z};
         tr_ff <= {req_test_value[31], req_test_value} + {2'b00, rad_ff};
         ux_ff <= req_dir_x;
         uy_ff <= req_dir_y;
         uz_ff <= req_dir_z;
         r1_ff <= rad_ff;
      end
   end

   // ---------------- S2: products ----------------
   logic signed [sprq_pkg::SQ_W-1:0]   sqx_in, sqy_in, sqz_in, tsq_in;
   logic [sprq_pkg::SQ_W-1:0]          sqx_ff, sqy_ff, sqz_ff, tsq_ff;
   logic signed [sprq_pkg::PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic [sprq_pkg::R2_W-1:0]          r2_ff;
   logic [30:0]                        r2s_ff;

   assign sqx_in = dx_ff * dx_ff;
   assign sqy_in = dy_ff * dy_ff;
   assign sqz_in = dz_ff * dz_ff;
   assign tsq_in = tr_ff * tr_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         sqz_ff <= sqz_in;
         tsq_ff <= tsq_in;
         px_ff  <= ux_ff * dx_ff;
         py_ff  <= uy_ff * dy_ff;
         pz_ff  <= uz_ff * dz_ff;
         r2_ff  <= r1_ff * r1_ff;
         r2s_ff <= r1_ff;
      end
   end

   // ---------------- S3: sums ----------------
   logic [sprq_pkg::SQ_W-1:0]        dist2_ff, tsq3_ff;
   logic signed [sprq_pkg::A1_W-1:0] a1_ff;
   logic [sprq_pkg::R2_W-1:0]        r23_ff;
   logic [30:0]                      r3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dist2_ff <= sqx_ff + sqy_ff + sqz_ff;
         a1_ff    <= sprq_pkg::A1_W'(px_ff) + sprq_pkg::A1_W'(py_ff)
                     + sprq_pkg::A1_W'(pz_ff);
         r23_ff   <= r2_ff;
         tsq3_ff  <= tsq_ff;
         r3_ff    <= r2s_ff;
      end
   end

   // ---------------- S4: compares, split square of a1 ----------------
   logic [sprq_pkg::SQ_W-1:0]  r2x;
   logic [sprq_pkg::SQ_W-1:0]  d0_diff;
   logic [sprq_pkg::AM_W-1:0]  am3;
   logic                       gt4, apos4;

   logic [DW-1:0]              a0s_ff;
   logic [2*sprq_pkg::ALO_W-1:0] pll_ff;
   logic [sprq_pkg::AHI_W+sprq_pkg::ALO_W-1:0] plh_ff;
   logic [2*sprq_pkg::AHI_W-1:0] phh_ff;
   logic                       hc4_ff, lt4_ff, wt4_ff;
   logic [sprq_pkg::AM_W-1:0]  am4_ff;
   logic [sprq_pkg::SQ_W-1:0]  dist4_ff;
   logic [30:0]                r4_ff;

   assign r2x     = sprq_pkg::SQ_W'(r23_ff);
   assign d0_diff = dist2_ff - r2x;
   assign am3     = a1_ff[sprq_pkg::AM_W-1:0];
   assign gt4     = dist2_ff > r2x;
   assign apos4   = !a1_ff[sprq_pkg::A1_W-1] && (a1_ff != '0);

   always_ff @(posedge clock) begin
      if (en) begin
         a0s_ff   <= DW'(d0_diff) << (2 * FRAC_BITS);
         pll_ff   <= am3[sprq_pkg::ALO_W-1:0] * am3[sprq_pkg::ALO_W-1:0];
         plh_ff   <= am3[sprq_pkg::AM_W-1:sprq_pkg::ALO_W] * am3[sprq_pkg::ALO_W-1:0];
         phh_ff   <= am3[sprq_pkg::AM_W-1:sprq_pkg::ALO_W]
                     * am3[sprq_pkg::AM_W-1:sprq_pkg::ALO_W];
         hc4_ff   <= gt4 && apos4;
         lt4_ff   <= dist2_ff < r2x;
         wt4_ff   <= dist2_ff < tsq3_ff;
         am4_ff   <= am3;
         dist4_ff <= dist2_ff;
         r4_ff    <= r3_ff;
      end
   end

   // ---------------- S5: assemble a1 squared ----------------
   logic [sprq_pkg::A1SQ_W-1:0] a1sq_ff;
   logic [DW-1:0]               a0s5_ff;
   logic                        hc5_ff, lt5_ff, wt5_ff;
   logic [sprq_pkg::AM_W-1:0]   am5_ff;
   logic [sprq_pkg::SQ_W-1:0]   dist5_ff;
   logic [30:0]                 r5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a1sq_ff  <= (sprq_pkg::A1SQ_W'(phh_ff) << (2 * sprq_pkg::ALO_W))
                     + (sprq_pkg::A1SQ_W'(plh_ff) << (sprq_pkg::ALO_W + 1))
                     + sprq_pkg::A1SQ_W'(pll_ff);
         a0s5_ff  <= a0s_ff;
         hc5_ff   <= hc4_ff;
         lt5_ff   <= lt4_ff;
         wt5_ff   <= wt4_ff;
         am5_ff   <= am4_ff;
         dist5_ff <= dist4_ff;
         r5_ff    <= r4_ff;
      end
   end

   // ---------------- S6: discriminant ----------------
   logic [DW-1:0]             a1sq_x;
   logic                      ok6;
   logic [DW-1:0]             disc_ff;
   logic                      ok_ff, lt6_ff, wt6_ff;
   logic [sprq_pkg::AM_W-1:0] am6_ff;
   logic [sprq_pkg::SQ_W-1:0] dist6_ff;
   logic [30:0]               r6_ff;

   assign a1sq_x = DW'(a1sq_ff);
   assign ok6    = hc5_ff && (a1sq_x >= a0s5_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         disc_ff  <= ok6 ? (a1sq_x - a0s5_ff) : '0;
         ok_ff    <= ok6;
         lt6_ff   <= lt5_ff;
         wt6_ff   <= wt5_ff;
         am6_ff   <= am5_ff;
         dist6_ff <= dist5_ff;
         r6_ff    <= r5_ff;
      end
   end

   // ---------------- root chain for the center distance ----------------
   logic [sprq_pkg::SQ_W-1:0]    remb_w  [0:QB];
   logic [sprq_pkg::ROOTB_W-1:0] rootb_w [0:QB];
   sideb_type                    sideb_w [0:QB];

   assign remb_w[0]  = dist6_ff;
   assign rootb_w[0] = '0;
   assign sideb_w[0] = '{disc: disc_ff, ok: ok_ff, am: am6_ff, r: r6_ff,
                         lt: lt6_ff, wt: wt6_ff};

   for (genvar k = 0; k < QB; k++) begin : g_cellb
      sprq_isqrt_cell #(
         .XW (sprq_pkg::SQ_W),
         .BIT(QB - 1 - k),
         .SW ($bits(sideb_type))
      ) u_cell (
         .clock (clock),
         .enable(en),
         .rem_i (remb_w[k]),
         .root_i(rootb_w[k]),
         .side_i(sideb_w[k]),
         .rem_o (remb_w[k+1]),
         .root_o(rootb_w[k+1]),
         .side_o(sideb_w[k+1])
      );
   end

   // ---------------- root chain for the ray discriminant ----------------
   logic [DW-1:0] rema_w  [0:QA];
   logic [QA-1:0] roota_w [0:QA];
   sidea_type     sidea_w [0:QA];
   sideb_type     sb_end;

   assign sb_end     = sideb_w[QB];
   assign rema_w[0]  = sb_end.disc;
   assign roota_w[0] = '0;
   assign sidea_w[0] = '{rootb: rootb_w[QB], ok: sb_end.ok, am: sb_end.am,
                         r: sb_end.r, lt: sb_end.lt, wt: sb_end.wt};

   for (genvar k = 0; k < QA; k++) begin : g_cella
      sprq_isqrt_cell #(
         .XW (DW),
         .BIT(QA - 1 - k),
         .SW ($bits(sidea_type))
      ) u_cell (
         .clock (clock),
         .enable(en),
         .rem_i (rema_w[k]),
         .root_i(roota_w[k]),
         .side_i(sidea_w[k]),
         .rem_o (rema_w[k+1]),
         .root_o(roota_w[k+1]),
         .side_o(sidea_w[k+1])
      );
   end

   // ---------------- final scaling and saturation ----------------
   sidea_type                 sa_end;
   logic [sprq_pkg::AM_W-1:0] ent_full, ent_sh;
   logic signed [34:0]        surf_full;
   sprq_pkg::rsp_type         res;

   assign sa_end    = sidea_w[QA];
   // root never exceeds a1, so the entry distance is non-negative
   assign ent_full  = sa_end.am - sprq_pkg::AM_W'(roota_w[QA]);
   assign ent_sh    = ent_full >> FRAC_BITS;
   assign surf_full = $signed({2'b00, sa_end.rootb}) - $signed({4'b0000, sa_end.r});

   always_comb begin
      res.ray_hit      = sa_end.ok;
      res.point_inside = sa_end.lt;
      res.within_test  = sa_end.wt;
      if (!sa_end.ok)
         res.hit_distance = '0;
      else if (|ent_sh[sprq_pkg::AM_W-1:31])
         res.hit_distance = 31'h7FFF_FFFF;
      else
         res.hit_distance = ent_sh[30:0];
      if (surf_full > 35'sd2147483647)
         res.surface_distance = 32'sh7FFF_FFFF;
      else if (surf_full < -35'sd2147483648)
         res.surface_distance = 32'sh8000_0000;
      else
         res.surface_distance = surf_full[31:0];
   end

   // ---------------- output register with skid slot ----------------
   logic              rsp_v_ff;
   sprq_pkg::rsp_type rsp_ff, skid_ff;
   logic              pipe_out;

   assign pipe_out = cv_ff[NC-1] && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (rsp_v_ff && !rsp_ready) begin
         // result held; a leaving item parks in the skid slot
         if (pipe_out) begin
            skid_v_ff <= 1'b1;
         end
      end else if (skid_v_ff) begin
         rsp_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end else begin
         rsp_v_ff  <= pipe_out;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_v_ff && !rsp_ready) begin
         if (pipe_out) begin
            skid_ff <= res;
         end
      end else if (skid_v_ff) begin
         rsp_ff <= skid_ff;
      end else if (pipe_out) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid            = rsp_v_ff;
   assign rsp_ray_hit          = rsp_ff.ray_hit;
   assign rsp_hit_distance     = rsp_ff.hit_distance;
   assign rsp_point_inside     = rsp_ff.point_inside;
   assign rsp_surface_distance = rsp_ff.surface_distance;
   assign rsp_within_test      = rsp_ff.within_test;
endmodule

[sv/sprq_isqrt_cell.sv]
// One cell of the pipelined integer square root: settles one root bit.
// No package dependencies; chained by sphere_ray_and_point_query.
module sprq_isqrt_cell #(
   parameter int XW  = 66,
   parameter int BIT = 0,
   parameter int SW  = 1
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [XW-1:0]       rem_i,
   input  logic [XW/2-1:0]     root_i,
   input  logic [SW-1:0]       side_i,
   output logic [XW-1:0]       rem_o,
   output logic [XW/2-1:0]     root_o,
   output logic [SW-1:0]       side_o
);
   localparam int QW = XW / 2;

   logic [XW:0]   trial;
   logic          take;
   logic [XW-1:0] rem_ff, rem_in;
   logic [QW-1:0] root_ff, root_in;
   logic [SW-1:0] side_ff;

   // (root + 2^b)^2 - root^2 = root*2^(b+1) + 4^b
   assign trial = ((XW+1)'(root_i) << (BIT + 1)) + ((XW+1)'(1) << (2 * BIT));
   assign take  = {1'b0, rem_i} >= trial;

   always_comb begin
      rem_in  = rem_i;
      root_in = root_i;
      if (take) begin
         rem_in  = rem_i - trial[XW-1:0];
         root_in = root_i | (QW'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_i;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign side_o = side_ff;
endmodule

[sv/sprq_checker.sv]
// Port-level checks for the sphere query unit, bound to the top level.
// Depends on sphere_ray_and_point_query_assert.svh.
`include "sphere_ray_and_point_query_assert.svh"
module sprq_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_ray_hit,
   input logic [30:0]         rsp_hit_distance,
   input logic                rsp_point_inside,
   input logic signed [31:0]  rsp_surface_distance
);
   // a stalled result keeps its payload
   `SPRQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_hit_distance) && $stable(rsp_surface_distance))
   // a miss reports zero distance
   `SPRQ_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_ray_hit,
      rsp_hit_distance == 31'd0)
   // an origin inside the sphere never yields a hit
   `SPRQ_ASSERT_NOW(a_inside_nohit, clock, reset, rsp_valid && rsp_point_inside,
      !rsp_ray_hit)
   // inside means a negative surface distance
   `SPRQ_ASSERT_NOW(a_inside_neg, clock, reset, rsp_valid && rsp_point_inside,
      rsp_surface_distance[31])
endmodule

bind sphere_ray_and_point_query sprq_checker u_sprq_checker (.*);

[test/tb.sv]
// Self-checking testbench for the sphere query unit (ray entry, containment,
// surface distance, threshold test). Needs sprq_pkg and sphere_ray_and_point_query.
`timescale 1ns / 100ps
module tb;

   localparam int     FRAC  = 16;
   localparam int     LAT   = 91;        // pipeline depth of the unit at the default FRAC_BITS
   localparam longint MIN32 = -64'sd2147483648;

   typedef struct {
      logic signed [31:0] px, py, pz;
      logic signed [17:0] ux, uy, uz;
      logic signed [31:0] tv;
   } query_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [sprq_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sprq_pkg::CSR_DAT_W-1:0] csr_wdata = '0;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [31:0]   req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic signed [17:0]   req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic signed [31:0]   req_test_value = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_ray_hit;
   logic [30:0]          rsp_hit_distance;
   logic                 rsp_point_inside;
   logic signed [31:0]   rsp_surface_distance;
   logic                 rsp_within_test;

   // local copy of the sphere registers
   logic signed [31:0]   sph_cx = '0, sph_cy = '0, sph_cz = '0;
   logic [30:0]          sph_rad = '0;

   sprq_pkg::rsp_type pending_results[$];
   int      n_errors    = 0;
   int      send_idle   = 0;       // percent of cycles the sender idles
   int      recv_stall  = 0;       // percent of cycles the receiver stalls
   int      hold_left   = 0;       // long receiver hold-off, in cycles

   sphere_ray_and_point_query u_dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [127:0] square_mag(input longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return m * m;
   endfunction

   // floor square root of a 128-bit value, one result bit per pass
   function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
      logic [63:0]  root;
      logic [63:0]  cand;
      root = '0;
      for (int i = 63; i >= 0; i--) begin
         cand = root | (64'd1 << i);
         if (128'(cand) * 128'(cand) <= x) root = cand;
      end
      return root;
   endfunction

   function automatic sprq_pkg::rsp_type sphere_answer(input query_type q);
      longint            dx, dy, dz, a1, surf, trad;
      logic [127:0]      d2, r2, a0s, a1sq;
      logic [63:0]       rt, dd;
      sprq_pkg::rsp_type o;
      dx = longint'(sph_cx) - longint'(q.px);
      dy = longint'(sph_cy) - longint'(q.py);
      dz = longint'(sph_cz) - longint'(q.pz);
      d2 = square_mag(dx) + square_mag(dy) + square_mag(dz);
      r2 = 128'(sph_rad) * 128'(sph_rad);
      a1 = longint'(q.ux) * dx + longint'(q.uy) * dy + longint'(q.uz) * dz;
      o = '0;
      // hit only from outside, ahead of the ray, with a real discriminant
      if (d2 > r2 && a1 > 0) begin
         a0s  = (d2 - r2) << (2 * FRAC);
         a1sq = square_mag(a1);
         if (a1sq >= a0s) begin
            rt = floor_sqrt(a1sq - a0s);
            dd = (64'(a1) - rt) >> FRAC;
            o.ray_hit = 1'b1;
            o.hit_distance = (dd > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : dd[30:0];
         end
      end
      o.point_inside = (d2 < r2);
      surf = longint'(floor_sqrt(d2)) - longint'(sph_rad);
      if (surf > 64'sd2147483647) surf = 64'sd2147483647;
      if (surf < -64'sd2147483648) surf = -64'sd2147483648;
      o.surface_distance = surf[31:0];
      trad = longint'(q.tv) + longint'(sph_rad);   // may go negative; squared anyway
      o.within_test = (d2 < square_mag(trad));
      return o;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic write_sphere_reg(input sprq_pkg::csr_index_type idx,
                                   input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      unique case (idx)
         sprq_pkg::CSR_CENTER_X: sph_cx = val;
         sprq_pkg::CSR_CENTER_Y: sph_cy = val;
         sprq_pkg::CSR_CENTER_Z: sph_cz = val;
         sprq_pkg::CSR_RADIUS:   sph_rad = val[30:0];
         default: ;
      endcase
   endtask

   task automatic set_sphere(input logic [31:0] cx, cy, cz, input logic [30:0] rad);
      write_sphere_reg(sprq_pkg::CSR_CENTER_X, cx);
      write_sphere_reg(sprq_pkg::CSR_CENTER_Y, cy);
      write_sphere_reg(sprq_pkg::CSR_CENTER_Z, cz);
      write_sphere_reg(sprq_pkg::CSR_RADIUS, {1'b0, rad});
   endtask

   // valid stays up between back-to-back transfers; only lowered for a gap
   task automatic send_query(input query_type q);
      while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_point_x    <= q.px;
      req_point_y    <= q.py;
      req_point_z    <= q.pz;
      req_dir_x      <= q.ux;
      req_dir_y      <= q.uy;
      req_dir_z      <= q.uz;
      req_test_value <= q.tv;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(sphere_answer(q));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
   end

   // result checker: every transfer is matched against the oldest prediction
   always @(posedge clock) begin
      sprq_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer");
            n_errors++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_ray_hit !== exp_r.ray_hit) begin
               $error("ray_hit exp %0d got %0d", exp_r.ray_hit, rsp_ray_hit);
               n_errors++;
            end
            if (rsp_hit_distance !== exp_r.hit_distance) begin
               $error("hit_distance exp %0d got %0d", exp_r.hit_distance, rsp_hit_distance);
               n_errors++;
            end
            if (rsp_point_inside !== exp_r.point_inside) begin
               $error("point_inside exp %0d got %0d", exp_r.point_inside, rsp_point_inside);
               n_errors++;
            end
            if (rsp_surface_distance !== exp_r.surface_distance) begin
               $error("surface_distance exp %0d got %0d",
                      exp_r.surface_distance, rsp_surface_distance);
               n_errors++;
            end
            if (rsp_within_test !== exp_r.within_test) begin
               $error("within_test exp %0d got %0d", exp_r.within_test, rsp_within_test);
               n_errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic query_type mk_query(input longint px, py, pz,
                                          input int ux, uy, uz, input longint tv);
      query_type q;
      q.px = 32'(px); q.py = 32'(py); q.pz = 32'(pz);
      q.ux = 18'(ux); q.uy = 18'(uy); q.uz = 18'(uz);
      q.tv = 32'(tv);
      return q;
   endfunction

   function automatic query_type noise_query();
      query_type q;
      q.px = $urandom; q.py = $urandom; q.pz = $urandom;
      q.ux = 18'($urandom); q.uy = 18'($urandom); q.uz = 18'($urandom);
      q.tv = $urandom;
      return q;
   endfunction

   // point a few radii from the center, ray roughly aimed back at it
   function automatic query_type aimed_query();
      query_type q;
      longint    span, ox, oy, oz;
      real       n;
      span = longint'(sph_rad) * 4 + 16;
      ox = longint'($urandom_range(0, 2 * span)) - span;
      oy = longint'($urandom_range(0, 2 * span)) - span;
      oz = longint'($urandom_range(0, 2 * span)) - span;
      q.px = 32'(longint'(sph_cx) - ox);
      q.py = 32'(longint'(sph_cy) - oy);
      q.pz = 32'(longint'(sph_cz) - oz);
      n = $sqrt($itor(ox) * $itor(ox) + $itor(oy) * $itor(oy) + $itor(oz) * $itor(oz));
      if (n == 0.0) n = 1.0;
      // jitter makes near misses and non-unit directions
      q.ux = 18'($rtoi(65536.0 * $itor(ox) / n) + $urandom_range(0, 6000) - 3000);
      q.uy = 18'($rtoi(65536.0 * $itor(oy) / n) + $urandom_range(0, 6000) - 3000);
      q.uz = 18'($rtoi(65536.0 * $itor(oz) / n) + $urandom_range(0, 6000) - 3000);
      if ($urandom_range(0, 5) == 0) begin
         q.ux = -q.ux; q.uy = -q.uy; q.uz = -q.uz;   // sphere behind the ray
      end
      q.tv = 32'(longint'($urandom_range(0, 2 * span)) - span);
      return q;
   endfunction

   task automatic test_directed();
      longint r;
      set_sphere(32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 31'h0004_0000);
      r = sph_rad;
      send_query(mk_query(sph_cx, sph_cy, sph_cz, 65536, 0, 0, 0));          // at center
      send_query(mk_query(sph_cx - r, sph_cy, sph_cz, 65536, 0, 0, 0));      // on surface
      send_query(mk_query(sph_cx - 4 * r, sph_cy, sph_cz, 65536, 0, 0, r));  // clean hit
      send_query(mk_query(sph_cx - 4 * r, sph_cy, sph_cz, -65536, 0, 0, r)); // behind
      send_query(mk_query(sph_cx - 4 * r, sph_cy + 2 * r, sph_cz, 65536, 0, 0, r)); // miss
      send_query(mk_query(sph_cx - 4 * r, sph_cy + r, sph_cz, 65536, 0, 0, r)); // grazing
      send_query(mk_query(sph_cx - 4 * r, sph_cy, sph_cz, 0, 0, 0, -r - 5));  // no direction
      send_query(mk_query(sph_cx - 4 * r, sph_cy, sph_cz, 131071, 131071, 131071, -3 * r));
      send_query(mk_query(sph_cx + 4 * r, sph_cy, sph_cz, -131072, -131072, -131072, 0));
      send_query(mk_query(MIN32, MIN32, MIN32, 65536, 65536, 65536, MIN32));
      send_query(mk_query(2147483647, 2147483647, 2147483647, -65536, -65536, -65536,
                          2147483647));
      send_query(mk_query(2147483647, MIN32, 0, -131072, 131071, 1, -1));
      wait_drained();
      // extreme sphere: far corner center, largest radius; surface distance saturates
      set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
      send_query(mk_query(2147483647, 2147483647, 2147483647, -65536, -65536, -65536, 0));
      send_query(mk_query(2147483647, 2147483647, 2147483647, -131072, -131072, -131072,
                          2147483647));
      send_query(mk_query(MIN32, MIN32, MIN32, 0, 0, 0, MIN32));
      send_query(mk_query(0, 0, 0, -65536, 0, 0, 0));
      send_query(mk_query(2147483647, MIN32, 2147483647, -65536, 0, -65536, 12345));
      wait_drained();
      // opposite corner center, zero radius: every point on or outside
      set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0);
      send_query(mk_query(2147483647, 2147483647, 2147483647, 65536, 0, 0, 0));
      send_query(mk_query(MIN32, MIN32, MIN32, 65536, 65536, 65536, 2147483647));
      send_query(mk_query(0, 0, 0, 37837, 37837, 37837, -7));
      wait_drained();
   endtask

   task automatic test_random(input int n, input int idle, input int stall);
      send_idle  = idle;
      recv_stall = stall;
      set_sphere($urandom_range(0, 32'h0400_0000) - 32'h0200_0000,
                 $urandom_range(0, 32'h0400_0000) - 32'h0200_0000,
                 $urandom_range(0, 32'h0400_0000) - 32'h0200_0000,
                 31'($urandom_range(1, 32'h0100_0000)));
      repeat (n) begin
         if ($urandom_range(0, 99) < 80) send_query(aimed_query());
         else send_query(noise_query());
      end
      wait_drained();
   endtask

   // receiver holds off long enough to fill the pipe and stall the input
   task automatic test_backpressure();
      send_idle  = 0;
      recv_stall = 0;
      hold_left  = 3 * LAT;
      repeat (150) send_query(aimed_query());
      wait_drained();    // sender pauses until every result is back
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150, 0, 0);
      test_random(150, 45, 0);
      test_random(150, 0, 45);
      test_random(150, 11, 11);
      test_backpressure();
      repeat (LAT + 20) @(posedge clock);
      if (n_errors == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
